/* hdl/plr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);   // holds 0 .. TABLE_DEPTH

    // Fixed field widths
    localparam int SLOT_W   = 12;
    localparam int START_W  = 32;
    localparam int LENGTH_W = 16;
    localparam int POS_W    = 32;
    localparam int INDEX_W  = 13;
    localparam int COUNT_W  = 13;
    localparam int SIZE_W   = 32;

    // Stream packing
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 16;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_RECORD_COUNT = 1'b0;
    localparam logic CFG_TEXT_SIZE    = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
    } tbl_wr_t;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] index;
    } res_t;

endpackage

`default_nettype wire

/* hdl/plr_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module plr_table
    import plr_pkg::*;
(
    input  wire logic                aclk,
    input  wire tbl_wr_t             wr,
    input  wire tbl_rd_t             rd,
    output logic [START_W-1:0]       rd_start,
    output logic [LENGTH_W-1:0]      rd_length
);

    logic [START_W-1:0]  start_mem  [TABLE_DEPTH];
    logic [LENGTH_W-1:0] length_mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            start_mem[wr.addr]  <= wr.start;
            length_mem[wr.addr] <= wr.length;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_start  <= start_mem[rd.addr];
            rd_length <= length_mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/plr_search.sv */
`timescale 1ns / 1ps
`default_nettype none

module plr_search
    import plr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // item side
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                in_opcode,
    input  wire logic [SLOT_W-1:0]   in_slot,
    input  wire logic [START_W-1:0]  in_start,
    input  wire logic [LENGTH_W-1:0] in_length,
    input  wire logic [POS_W-1:0]    in_position,
    // configuration
    input  wire logic [CNT_W-1:0]    count_eff,
    input  wire logic [SIZE_W-1:0]   text_size,
    // table ports
    output tbl_wr_t                  wr,
    output tbl_rd_t                  rd,
    input  wire logic [START_W-1:0]  rd_start,
    input  wire logic [LENGTH_W-1:0] rd_length,
    // result side
    output logic                     res_valid,
    input  wire logic                res_ready,
    output res_t                     res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    localparam int WIDE_W = SLOT_W + CNT_W;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] half_reg, half_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    res_t             res_reg, res_next;

    logic [CNT_W-1:0]   probe;
    logic [CNT_W-1:0]   hi_base;
    logic [CNT_W-1:0]   hi_size;
    logic [CNT_W-1:0]   nb;
    logic [CNT_W-1:0]   ns;
    logic [CNT_W-1:0]   nh;
    logic [CNT_W-1:0]   next_probe;
    logic [START_W:0]   end_pos;
    logic               below;
    logic               above;
    logic               slot_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Probe arithmetic runs on narrow index values beside the wide compare
    assign probe      = base_reg + half_reg;
    assign hi_base    = base_reg + half_reg + CNT_W'(1);
    assign hi_size    = size_reg[0] ? half_reg : half_reg - CNT_W'(1);
    assign end_pos    = {1'b0, rd_start} + (START_W + 1)'(rd_length);
    assign below      = pos_reg < rd_start;
    assign above      = {1'b0, pos_reg} > end_pos;
    assign nb         = above ? hi_base : base_reg;
    assign ns         = above ? hi_size : half_reg;
    assign nh         = ns >> 1;
    assign next_probe = nb + nh;
    assign slot_ok    = WIDE_W'(in_slot) < WIDE_W'(TABLE_DEPTH);

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        size_next  = size_reg;
        half_next  = half_reg;
        pos_next   = pos_reg;
        res_next   = res_reg;
        rd         = '0;
        wr         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DONE;
                    if (in_opcode == OP_WRITE) begin
                        wr.en        = slot_ok;
                        wr.addr      = ADDR_W'(in_slot);
                        wr.start     = in_start;
                        wr.length    = in_length;
                        res_next     = '{status: STATUS_OK, index: INDEX_W'(in_slot)};
                    end else if (in_position >= text_size) begin
                        res_next     = '{status: STATUS_RANGE, index: '0};
                    end else if (count_eff == '0) begin
                        res_next     = '{status: STATUS_OK, index: '0};
                    end else begin
                        rd.en        = 1'b1;
                        rd.addr      = ADDR_W'(count_eff >> 1);
                        base_next    = '0;
                        size_next    = count_eff;
                        half_next    = count_eff >> 1;
                        pos_next     = in_position;
                        state_next   = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (!below && !above) begin
                    res_next   = '{status: STATUS_OK, index: INDEX_W'(probe)};
                    state_next = ST_DONE;
                end else if (ns == '0) begin
                    res_next   = '{status: STATUS_OK, index: INDEX_W'(nb)};
                    state_next = ST_DONE;
                end else begin
                    // issue the next probe straight from the compare
                    rd.en     = 1'b1;
                    rd.addr   = next_probe[ADDR_W-1:0];
                    base_next = nb;
                    size_next = ns;
                    half_next = nh;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        size_reg <= size_next;
        half_reg <= half_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

/* hdl/position_to_record_lookup_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Position-to-record lookup over a sorted table of (start, length) records.
// Input stream (s_axis_*): tuser selects the beat kind. A write beat stores
// one table entry and answers with status ok and the echoed slot. A query
// beat locates a text position: at or beyond text_size it answers with the
// out-of-range status and index 0; otherwise a binary search over the first
// record_count entries returns the holding record (end point inclusive) or
// the insertion point.
// Result stream (m_axis_*): one beat per input beat, in order.
// Config channel (cfg_*): index 0 is record_count, index 1 is text_size;
// always ready, write only while the block is idle.
// Timing: a write or out-of-range beat passes through the result register
// in the search engine and then the output register before m_axis_tvalid
// rises; a query first runs its table probes, each one read of the
// synchronous table memory, up to 13 for a full table of 4096 records.
// Items are handled one at a time: a new beat is taken only while idle.
// Reset clears the configuration registers and the control; table contents stay undefined
// until written. A stalled receiver holds the result in the output register;
// the engine then finishes its next item and waits for the register to free.

module position_to_record_lookup_core
    import plr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // entry_slot, entry_start, entry_length, position
    input  wire logic                  s_axis_tuser,  // opcode
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,  // record_index
    output logic                       m_axis_tuser,  // status
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [SIZE_W-1:0]     cfg_data
);

    localparam int WIDE_W = COUNT_W + CNT_W;

    logic [COUNT_W-1:0] record_count_reg;
    logic [SIZE_W-1:0]  text_size_reg;
    logic [CNT_W-1:0]   count_eff;

    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg;

    tbl_wr_t              tbl_wr;
    tbl_rd_t              tbl_rd;
    logic [START_W-1:0]   rd_start;
    logic [LENGTH_W-1:0]  rd_length;
    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;

    // Unpack the input beat
    logic [SLOT_W-1:0]   in_slot;
    logic [START_W-1:0]  in_start;
    logic [LENGTH_W-1:0] in_length;
    logic [POS_W-1:0]    in_position;

    assign in_slot     = s_axis_tdata[SLOT_W-1:0];
    assign in_start    = s_axis_tdata[SLOT_W +: START_W];
    assign in_length   = s_axis_tdata[SLOT_W + START_W +: LENGTH_W];
    assign in_position = s_axis_tdata[SLOT_W + START_W + LENGTH_W +: POS_W];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_count_reg <= '0;
            text_size_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RECORD_COUNT: record_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_TEXT_SIZE:    text_size_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Saturate the record count to the table depth
    assign count_eff = (WIDE_W'(record_count_reg) > WIDE_W'(TABLE_DEPTH))
                       ? CNT_W'(TABLE_DEPTH) : CNT_W'(record_count_reg);

    plr_table u_table (
        .aclk      (aclk),
        .wr        (tbl_wr),
        .rd        (tbl_rd),
        .rd_start  (rd_start),
        .rd_length (rd_length)
    );

    plr_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_opcode   (s_axis_tuser),
        .in_slot     (in_slot),
        .in_start    (in_start),
        .in_length   (in_length),
        .in_position (in_position),
        .count_eff   (count_eff),
        .text_size   (text_size_reg),
        .wr          (tbl_wr),
        .rd          (tbl_rd),
        .rd_start    (rd_start),
        .rd_length   (rd_length),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register: take a result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = M_TDATA_W'(out_res_reg.index);

`ifndef SYNTHESIS
    // An out-of-range answer always carries index zero
    a_range_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == STATUS_RANGE)) |-> (out_res_reg.index == '0))
        else $error("out-of-range result with nonzero index");

    // Table reads and writes never overlap
    a_no_rd_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tbl_rd.en && tbl_wr.en))
        else $error("table read and write in the same cycle");

    // Every probe stays inside the searched records
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_rd.en |-> (CNT_W'(tbl_rd.addr) < count_eff))
        else $error("probe beyond record count");

    // A result waiting in the engine is moved only when the output slot frees
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_res_reg))
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire
